// ===== hdl/ed_pkg.sv =====
package ed_pkg;

   localparam int MAX_DIM = 256;
   localparam int COUNT_W = $clog2(MAX_DIM + 1);
   localparam int ELEM_W = 16;
   localparam int MAG_W = ELEM_W + 1;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_W = 41;
   localparam int DIST_W = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(1) << (SUM_W - 1);
   localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 1);

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             last;
   } ed_item_type;

endpackage

// ===== hdl/euclidean_distance_top.sv =====
// Streaming Euclidean distance between two vectors of signed Q8.8 elements.
// Each request on the req_ channel carries one element pair and a flag that
// marks the last pair of the vector. The front end forms the magnitude of the
// difference and places it in a four-entry queue; the back end squares it,
// adds it to a Q25.16 running sum and, after the last pair, runs a
// digit-by-digit square root that resolves one result bit per cycle.
// One result appears on the rsp_ channel per vector: the distance in
// unsigned Q13.8 and a flag that is set if the sum saturated or the vector
// had more than 256 elements. Requests that are not last give no result.
// Throughput is one element pair per cycle while a vector streams in and the
// queue is not full. With an idle back end, the last request passes through
// the queue and the square stage, the square root resolves the result bits,
// and the result is then loaded into the output register. During
// the root, the queue keeps taking requests of the next vector until it fills.
// When the receiver stalls, the result waits in the output register and the
// back end holds the next result, so the queue then fills and req_ready
// falls. Synchronous reset empties the queue, clears the sum, count and
// flag, and drops any pending result.
module euclidean_distance_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [ed_pkg::ELEM_W-1:0] req_a_element,
   input  logic signed [ed_pkg::ELEM_W-1:0] req_b_element,
   input  logic                             req_last_element,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ed_pkg::DIST_W-1:0]        rsp_distance,
   output logic                             rsp_saturated
);
   import ed_pkg::*;

   ed_item_type push_item;
   ed_item_type head_item;
   logic        queue_push;
   logic        queue_pop;
   logic        queue_full;
   logic        queue_empty;

   ed_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_a_element    (req_a_element),
      .req_b_element    (req_b_element),
      .req_last_element (req_last_element),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_item       (push_item)
   );

   ed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .pop       (queue_pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   ed_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .queue_empty   (queue_empty),
      .queue_pop     (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_distance  (rsp_distance),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== hdl/ed_front.sv =====
module ed_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ed_pkg::ELEM_W-1:0] req_a_element,
   input  logic signed [ed_pkg::ELEM_W-1:0] req_b_element,
   input  logic                          req_last_element,
   input  logic                          queue_full,
   output logic                          queue_push,
   output ed_pkg::ed_item_type           queue_item
);
   import ed_pkg::*;

   logic signed [MAG_W-1:0] diff;

   always_comb begin
      diff = MAG_W'(req_b_element) - MAG_W'(req_a_element);
      queue_item.mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      queue_item.last = req_last_element;
   end

   assign req_ready = !queue_full;
   assign queue_push = req_valid && !queue_full;

endmodule

// ===== hdl/ed_queue.sv =====
module ed_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ed_pkg::ed_item_type push_item,
   input  logic                pop,
   output ed_pkg::ed_item_type head_item,
   output logic                full,
   output logic                empty
);
   import ed_pkg::*;

   ed_item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff;
   logic [QPTR_W-1:0]       wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff;
   logic [QPTR_W-1:0]       rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff;
   logic [QCNT_W-1:0]       count_in;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/ed_back.sv =====
module ed_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ed_pkg::ed_item_type       head_item,
   input  logic                      queue_empty,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ed_pkg::DIST_W-1:0] rsp_distance,
   output logic                      rsp_saturated
);
   import ed_pkg::*;

   typedef enum logic [1:0] {ST_ACCUM, ST_ROOT, ST_DELIVER} state_type;

   state_type          state_ff;
   state_type          state_in;
   logic               sq_valid_ff;
   logic               sq_valid_in;
   logic               sq_last_ff;
   logic               sq_last_in;
   logic [SQ_W-1:0]    sq_ff;
   logic [SQ_W-1:0]    sq_in;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic [SUM_W-1:0]   rad_ff;
   logic [SUM_W-1:0]   rad_in;
   logic [SUM_W:0]     root_ff;
   logic [SUM_W:0]     root_in;
   logic [SUM_W-1:0]   bit_ff;
   logic [SUM_W-1:0]   bit_in;
   logic               sat_hold_ff;
   logic               sat_hold_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [DIST_W-1:0]  distance_ff;
   logic [DIST_W-1:0]  distance_in;
   logic               saturated_ff;
   logic               saturated_in;

   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   acc_sum;
   logic [COUNT_W-1:0] acc_count;
   logic               acc_ovf;
   logic [SUM_W:0]     trial;

   assign queue_pop = (state_ff == ST_ACCUM) && !queue_empty && !(sq_valid_ff && sq_last_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance = distance_ff;
   assign rsp_saturated = saturated_ff;

   always_comb begin
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
      if (count_ff >= COUNT_W'(MAX_DIM)) begin
         acc_sum = SUM_CAP;
         acc_ovf = 1'b1;
         acc_count = count_ff;
      end else if (sum_wide > {1'b0, SUM_CAP}) begin
         acc_sum = SUM_CAP;
         acc_ovf = 1'b1;
         acc_count = count_ff + 1'b1;
      end else begin
         acc_sum = sum_wide[SUM_W-1:0];
         acc_ovf = ovf_ff;
         acc_count = count_ff + 1'b1;
      end
      trial = root_ff + {1'b0, bit_ff};

      state_in = state_ff;
      sq_valid_in = queue_pop;
      sq_last_in = head_item.last;
      sq_in = SQ_W'(head_item.mag) * SQ_W'(head_item.mag);
      sum_in = sum_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      sat_hold_in = sat_hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      distance_in = distance_ff;
      saturated_in = saturated_ff;

      case (state_ff)
         ST_ACCUM: begin
            if (sq_valid_ff) begin
               if (sq_last_ff) begin
                  sum_in = '0;
                  count_in = '0;
                  ovf_in = 1'b0;
                  rad_in = acc_sum;
                  root_in = '0;
                  bit_in = ROOT_BIT_INIT;
                  sat_hold_in = acc_ovf;
                  state_in = ST_ROOT;
               end else begin
                  sum_in = acc_sum;
                  count_in = acc_count;
                  ovf_in = acc_ovf;
               end
            end
         end
         ST_ROOT: begin
            if ({1'b0, rad_ff} >= trial) begin
               rad_in = rad_ff - trial[SUM_W-1:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               distance_in = root_ff[DIST_W-1:0];
               saturated_in = sat_hold_ff;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sq_last_ff <= sq_last_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      sat_hold_ff <= sat_hold_in;
      distance_ff <= distance_in;
      saturated_ff <= saturated_in;
      if (reset) begin
         state_ff <= ST_ACCUM;
         sq_valid_ff <= 1'b0;
         sum_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sq_valid_ff <= sq_valid_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
